/* rtl/dda_line_rasterizer_defines.svh */
`ifndef DDA_LINE_RASTERIZER_DEFINES_SVH
`define DDA_LINE_RASTERIZER_DEFINES_SVH

// same-cycle implication, checked on clk, off during reset
`define DDA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DDA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/dda_pkg.sv */
package dda_pkg;

  typedef struct packed {
    logic load;
    logic iter;
    logic emit;
  } dda_cmd_t;

  typedef struct packed {
    logic active;
  } dda_status_t;

endpackage

/* rtl/dda_ctrl.sv */
`include "dda_line_rasterizer_defines.svh"

module dda_ctrl #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic               in_tuser,
  output logic               out_tvalid,
  input  logic               out_tready,
  output dda_pkg::dda_cmd_t  cmd,
  input  dda_pkg::dda_status_t status
);
  import dda_pkg::*;

  localparam int CW = $clog2(FRAC_BITS + 1);
  localparam logic S_IDLE = 1'b0;
  localparam logic S_DIV  = 1'b1;

  logic          state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          in_acc;
  logic          div_done;

  assign in_tready  = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign div_done   = (state_r == S_DIV) && (cnt_r == CW'(FRAC_BITS));

  assign cmd.load = in_acc && !in_tuser;
  assign cmd.iter = (state_r == S_DIV);
  assign cmd.emit = in_acc && in_tuser && status.active;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.load) begin
          state_nxt = S_DIV;
          cnt_nxt   = '0;
        end
      end
      S_DIV: begin
        cnt_nxt = cnt_r + CW'(1);
        if (div_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `DDA_ASSERT_IMPL(a_emit_room, cmd.emit, !out_valid_r || out_tready, "emit into full output")
  `DDA_ASSERT_NEXT(a_load_div, cmd.load, state_r == S_DIV && cnt_r == '0, "no divide start")
  `DDA_ASSERT_NEXT(a_div_end, div_done, state_r == S_IDLE, "divide overran its count")

endmodule

/* rtl/dda_dp.sv */
`include "dda_line_rasterizer_defines.svh"

module dda_dp #(
  parameter int COORD_BITS = 10,
  parameter int FRAC_BITS  = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dda_pkg::dda_cmd_t       cmd,
  output dda_pkg::dda_status_t    status,
  input  logic [COORD_BITS-1:0]   start_x,
  input  logic [COORD_BITS-1:0]   start_y,
  input  logic [COORD_BITS-1:0]   end_x,
  input  logic [COORD_BITS-1:0]   end_y,
  output logic [COORD_BITS-1:0]   pixel_x,
  output logic [COORD_BITS-1:0]   pixel_y,
  output logic                    last
);
  import dda_pkg::*;

  localparam int AW = COORD_BITS + FRAC_BITS;
  localparam int QW = FRAC_BITS + 1;
  localparam int RW = COORD_BITS + 1;

  logic [COORD_BITS-1:0] start_c [2];
  logic [COORD_BITS-1:0] end_c   [2];
  logic [RW-1:0]         delta   [2];
  logic [COORD_BITS-1:0] mag     [2];
  logic [COORD_BITS-1:0] steps_c;

  logic [AW-1:0]         acc_r [2], acc_nxt [2];
  logic [QW-1:0]         quot_r [2], quot_nxt [2];
  logic [RW-1:0]         rem_r [2], rem_nxt [2];
  logic [RW-1:0]         rem_diff [2];
  logic                  neg_r [2], neg_nxt [2];
  logic [AW-1:0]         rnd [2];
  logic [COORD_BITS-1:0] pix_r [2], pix_nxt [2];
  logic [COORD_BITS-1:0] steps_r, steps_nxt;
  logic                  last_r, last_nxt;
  logic [RW-1:0]         left_r, left_nxt;
  logic                  active_r, active_nxt;

  assign start_c[0] = start_x;
  assign start_c[1] = start_y;
  assign end_c[0]   = end_x;
  assign end_c[1]   = end_y;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      delta[i] = {1'b0, end_c[i]} - {1'b0, start_c[i]};
      mag[i]   = delta[i][RW-1] ? COORD_BITS'(-delta[i]) : delta[i][COORD_BITS-1:0];
    end
    steps_c = (mag[0] > mag[1]) ? mag[0] : mag[1];
  end

  always_comb begin
    steps_nxt  = steps_r;
    last_nxt   = last_r;
    left_nxt   = left_r;
    active_nxt = active_r;
    for (int i = 0; i < 2; i++) begin
      acc_nxt[i]  = acc_r[i];
      quot_nxt[i] = quot_r[i];
      rem_nxt[i]  = rem_r[i];
      neg_nxt[i]  = neg_r[i];
      pix_nxt[i]  = pix_r[i];
      rnd[i]      = acc_r[i] + (AW'(1) << (FRAC_BITS - 1));
      rem_diff[i] = (rem_r[i] >= {1'b0, steps_r}) ? rem_r[i] - {1'b0, steps_r} : rem_r[i];
      if (cmd.load) begin
        acc_nxt[i] = {start_c[i], {FRAC_BITS{1'b0}}};
        rem_nxt[i] = {1'b0, mag[i]};
        neg_nxt[i] = delta[i][RW-1];
        quot_nxt[i] = '0;
      end else if (cmd.iter) begin
        // restoring divide, one quotient bit a cycle
        quot_nxt[i] = {quot_r[i][QW-2:0], rem_r[i] >= {1'b0, steps_r}};
        rem_nxt[i]  = {rem_diff[i][COORD_BITS-1:0], 1'b0};
      end else if (cmd.emit) begin
        pix_nxt[i] = rnd[i][AW-1:FRAC_BITS];
        acc_nxt[i] = neg_r[i] ? acc_r[i] - AW'(quot_r[i]) : acc_r[i] + AW'(quot_r[i]);
      end
    end
    if (cmd.load) begin
      steps_nxt  = steps_c;
      left_nxt   = {1'b0, steps_c} + RW'(1);
      active_nxt = 1'b1;
    end else if (cmd.emit) begin
      last_nxt = (left_r == RW'(1));
      left_nxt = left_r - RW'(1);
      if (left_r == RW'(1)) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      active_r <= 1'b0;
    end else begin
      left_r   <= left_nxt;
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    steps_r <= steps_nxt;
    last_r  <= last_nxt;
    for (int i = 0; i < 2; i++) begin
      acc_r[i]  <= acc_nxt[i];
      quot_r[i] <= quot_nxt[i];
      rem_r[i]  <= rem_nxt[i];
      neg_r[i]  <= neg_nxt[i];
      pix_r[i]  <= pix_nxt[i];
    end
  end

  assign status.active = active_r;
  assign pixel_x       = pix_r[0];
  assign pixel_y       = pix_r[1];
  assign last          = last_r;

  `DDA_ASSERT_IMPL(a_active_left, active_r, left_r != '0, "active line with no pixels left")
  `DDA_ASSERT_NEXT(a_load_active, cmd.load, active_r, "line not active after load")
  `DDA_ASSERT_NEXT(a_load_count, cmd.load, left_r == {1'b0, steps_r} + RW'(1), "bad load count")
  `DDA_ASSERT_IMPL(a_rem_x, cmd.iter, rem_r[0] <= {steps_r, 1'b0}, "x remainder out of range")
  `DDA_ASSERT_IMPL(a_rem_y, cmd.iter, rem_r[1] <= {steps_r, 1'b0}, "y remainder out of range")

endmodule

/* rtl/dda_line_rasterizer.sv */
// channel  dir  tdata                                   tuser  tlast
// in_      in   start_x, start_y, end_x, end_y          cmd    -
// out_     out  pixel_x, pixel_y                        -      last
// a step word yields at most one pixel word
// a load word is accepted, then divided, one quotient bit a cycle
//   from a restoring divider on each axis, both sharing the step count
// in_tready is low during the divide and while an unaccepted pixel word is held
// rst_n is synchronous, active low, and clears the line and the output valid flag
module dda_line_rasterizer #(
  parameter int COORD_BITS = 10,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // start_x, start_y, end_x, end_y
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]       in_tdata,
  // cmd
  input  logic                                    in_tuser,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // pixel_x, pixel_y
  output logic [((2*COORD_BITS+7)/8)*8-1:0]       out_tdata,
  output logic                                    out_tlast
);
  import dda_pkg::*;

  localparam int OW = ((2*COORD_BITS+7)/8)*8;

  dda_cmd_t              cmd;
  dda_status_t           status;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;

  dda_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .status     (status)
  );

  dda_dp #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .status  (status),
    .start_x (in_tdata[COORD_BITS-1:0]),
    .start_y (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .end_x   (in_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .end_y   (in_tdata[4*COORD_BITS-1:3*COORD_BITS]),
    .pixel_x (pixel_x),
    .pixel_y (pixel_y),
    .last    (out_tlast)
  );

  assign out_tdata = OW'({pixel_y, pixel_x});

endmodule

/* bench/tb_dda_line_rasterizer.sv */
module tb_dda_line_rasterizer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_BITS = 10;
  localparam int FRAC_BITS  = 16;
  localparam int IN_W       = ((4*COORD_BITS+7)/8)*8;
  localparam int OUT_W      = ((2*COORD_BITS+7)/8)*8;
  localparam int COORD_MAX  = (1 << COORD_BITS) - 1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef struct {
    logic                  cmd;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
    bit                    drain_first;
    bit                    quick;
  } word_t;

  typedef struct {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  last;
  } pixel_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             in_tuser = CMD_LOAD;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tlast;

  // line state as the block keeps it
  logic signed [26:0] pos_x, pos_y;
  logic signed [17:0] inc_x, inc_y;
  logic [10:0]        pix_left;
  logic               line_on;

  word_t  word_q[$];
  pixel_t pixel_q[$];
  word_t  cur_word;
  pixel_t want;
  int     tx_gap;
  int     rx_gap;
  bit     rx_quick;
  int     mismatches;

  dda_line_rasterizer #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  function automatic logic signed [17:0] slope_q16(input int delta, input int span);
    logic [26:0] num;
    logic [17:0] mag;
    if (span == 0) return '0;
    num = 27'(delta < 0 ? -delta : delta) << FRAC_BITS;
    mag = 18'(num / 27'(span));
    return (delta < 0) ? -$signed(mag) : $signed(mag);
  endfunction

  // round half up to a whole coordinate
  function automatic logic [COORD_BITS-1:0] round_pos(input logic signed [26:0] pos);
    logic [26:0] r;
    r = pos + (27'd1 << (FRAC_BITS - 1));
    return r[FRAC_BITS +: COORD_BITS];
  endfunction

  task automatic rasterize_word(input word_t w);
    int     dx, dy, ax, ay, span;
    pixel_t px;
    if (w.cmd == CMD_LOAD) begin
      dx = int'(w.end_x) - int'(w.start_x);
      dy = int'(w.end_y) - int'(w.start_y);
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      span = ax > ay ? ax : ay;
      pos_x = 27'(w.start_x) << FRAC_BITS;
      pos_y = 27'(w.start_y) << FRAC_BITS;
      inc_x = slope_q16(dx, span);
      inc_y = slope_q16(dy, span);
      pix_left = 11'(span + 1);
      line_on = 1'b1;
    end else if (line_on) begin
      px.pixel_x = round_pos(pos_x);
      px.pixel_y = round_pos(pos_y);
      px.last = (pix_left == 11'd1);
      pixel_q.push_back(px);
      pos_x = pos_x + inc_x;
      pos_y = pos_y + inc_y;
      pix_left = pix_left - 11'd1;
      if (pix_left == 11'd0) line_on = 1'b0;
    end
  endtask

  task automatic add_word(input logic cmd, input int sx, input int sy, input int ex,
                          input int ey, input bit drain, input bit quick);
    word_t w;
    w.cmd = cmd;
    w.start_x = COORD_BITS'(sx);
    w.start_y = COORD_BITS'(sy);
    w.end_x = COORD_BITS'(ex);
    w.end_y = COORD_BITS'(ey);
    w.drain_first = drain;
    w.quick = quick;
    word_q.push_back(w);
  endtask

  // load then a run of step words with junk in the unused fields
  task automatic add_line(input int sx, input int sy, input int ex, input int ey,
                          input int n_steps, input bit drain, input bit quick);
    add_word(CMD_LOAD, sx, sy, ex, ey, drain, quick);
    repeat (n_steps)
      add_word(CMD_STEP, $urandom, $urandom, $urandom, $urandom, 1'b0, quick);
  endtask

  function automatic int end_near(input int s, input int span);
    int e;
    e = s + int'($urandom_range(0, 2*span)) - span;
    if (e < 0) e = 0;
    if (e > COORD_MAX) e = COORD_MAX;
    return e;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= CMD_LOAD;
      pos_x = '0;
      pos_y = '0;
      inc_x = '0;
      inc_y = '0;
      pix_left = '0;
      line_on = 1'b0;
      tx_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        rasterize_word(cur_word);
        tx_gap = cur_word.quick ? 0 : $urandom_range(0, 4);
      end
      if (!in_tvalid || in_tready) begin
        if (tx_gap == 0 && word_q.size() != 0 &&
            (!word_q[0].drain_first || pixel_q.size() == 0)) begin
          cur_word = word_q.pop_front();
          rx_quick = cur_word.quick;
          in_tvalid <= 1'b1;
          in_tdata <= IN_W'({cur_word.end_y, cur_word.end_x,
                             cur_word.start_y, cur_word.start_x});
          in_tuser <= cur_word.cmd;
        end else begin
          in_tvalid <= 1'b0;
          if (tx_gap > 0) tx_gap--;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_gap = 0;
    end else if (out_tvalid && out_tready) begin
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected pixel word, expected none, got x=%0d y=%0d last=%0d",
                 $time, out_tdata[COORD_BITS-1:0],
                 out_tdata[2*COORD_BITS-1:COORD_BITS], out_tlast);
        mismatches++;
      end else begin
        want = pixel_q.pop_front();
        if (out_tdata[COORD_BITS-1:0] !== want.pixel_x ||
            out_tdata[2*COORD_BITS-1:COORD_BITS] !== want.pixel_y ||
            out_tlast !== want.last) begin
          $display("%0t: pixel mismatch, expected x=%0d y=%0d last=%0d, got x=%0d y=%0d last=%0d",
                   $time, want.pixel_x, want.pixel_y, want.last,
                   out_tdata[COORD_BITS-1:0], out_tdata[2*COORD_BITS-1:COORD_BITS],
                   out_tlast);
          mismatches++;
        end
      end
      rx_gap = rx_quick ? 0 : $urandom_range(0, 4);
      out_tready <= (rx_gap == 0);
    end else if (!out_tready) begin
      if (rx_gap <= 1) out_tready <= 1'b1;
      if (rx_gap > 0) rx_gap--;
    end
  end

  initial begin
    int sx, sy, ex, ey, span, len, n_steps;
    mismatches = 0;
    rx_quick = 1'b0;

    // step with no line, zero-length line, abandoned full-range lines
    add_word(CMD_STEP, 0, 0, 0, 0, 1'b0, 1'b0);
    add_line(5, 7, 5, 7, 2, 1'b0, 1'b0);
    add_line(0, 0, COORD_MAX, COORD_MAX, 2, 1'b0, 1'b1);
    add_line(COORD_MAX, COORD_MAX, 0, 0, 2, 1'b0, 1'b0);
    add_line(COORD_MAX, COORD_MAX, COORD_MAX - 2, COORD_MAX - 3, 4, 1'b1, 1'b0);
    // exact half position reached through a truncated slope rounds down
    add_line(0, 0, 6, 1, 7, 1'b0, 1'b0);

    while (word_q.size() < 925) begin
      if ($urandom_range(0, 9) < 8) begin
        sx = $urandom_range(0, COORD_MAX);
        sy = $urandom_range(0, COORD_MAX);
        span = ($urandom_range(0, 9) == 0) ? COORD_MAX : 15;
        ex = end_near(sx, span);
        ey = end_near(sy, span);
        len = (ex > sx ? ex - sx : sx - ex);
        if ((ey > sy ? ey - sy : sy - ey) > len) len = (ey > sy ? ey - sy : sy - ey);
        len++;
        n_steps = len + $urandom_range(0, 2);
        if ($urandom_range(0, 7) == 0) n_steps = $urandom_range(0, len);
        if (n_steps > 64 && $urandom_range(0, 3) != 0) n_steps = $urandom_range(1, 40);
        add_line(sx, sy, ex, ey, n_steps, $urandom_range(0, 19) == 0,
                 $urandom_range(0, 3) == 0);
      end else begin
        add_word(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom,
                 1'b0, 1'b0);
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (word_q.size() != 0 || in_tvalid) @(posedge clk);
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pixel_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/dda_pkg.sv
rtl/dda_ctrl.sv
rtl/dda_dp.sv
rtl/dda_line_rasterizer.sv
bench/tb_dda_line_rasterizer.sv
